### rtl/core/key_short_long_press_detector_unit_assert.svh
// Assertion macros for the key press detector.
`ifndef KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH
`define KEY_SHORT_LONG_PRESS_DETECTOR_UNIT_ASSERT_SVH

// Overlapping implication: antecedent and consequent in the same cycle.
`define KPD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpd assertion failed");

// Next-cycle implication.
`define KPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpd assertion failed");

`endif

### rtl/core/kpd_pkg.sv
`default_nettype none
package kpd_pkg;

	localparam int KEYS        = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int LEVEL_BITS  = 4;
	localparam int STATES_BITS = 8;
	localparam int THR_WIDTH   = 16;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [1:0]             pstate_t;

	localparam cnt_t CNT_MAX = '1;

	localparam pstate_t ST_RELEASED = 2'd0;
	localparam pstate_t ST_SHORT    = 2'd1;
	localparam pstate_t ST_LONG     = 2'd2;

	localparam logic [1:0] FN_SCAN    = 2'd0;
	localparam logic [1:0] FN_CLR_ONE = 2'd1;
	localparam logic [1:0] FN_CLR_ALL = 2'd2;

	localparam logic [1:0] REG_LONG_TICKS = 2'd0;
	localparam logic [1:0] REG_MIN_TICKS  = 2'd1;
	localparam logic [1:0] REG_REL_LEVEL  = 2'd2;

	localparam logic [THR_WIDTH-1:0] LONG_TICKS_RST = 16'd100;
	localparam logic [THR_WIDTH-1:0] MIN_TICKS_RST  = 16'd2;

	typedef struct packed {
		logic [STATES_BITS-1:0] key_states;
		logic                   any_active;
		logic                   beep;
	} res_t;

endpackage
`default_nettype wire

### rtl/core/key_short_long_press_detector_unit.sv
// Channel | Direction | Handshake         | Word
// in      | sink      | in_valid/in_stall | func, key_levels, key_select
// out     | source    | out_valid/out_stall | key_states, any_active, beep
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word per cycle while in_stall is low; a result is presented the cycle after its
// word is taken unless the output is stalled, in which case it waits in the skid register.
// All keys update in parallel in one pass from the state registers to the result register.
// A skid register behind the result register keeps input flowing for one stalled word;
// in_stall rises only when the skid register is full.
// Reset clears key states, counters, locks and loads the default thresholds.
`default_nettype none
module key_short_long_press_detector_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [3:0]  key_levels,
	input  wire logic [1:0]  key_select,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       key_states,
	output logic             any_active,
	output logic             beep,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int K = kpd_pkg::KEYS;

	logic [kpd_pkg::THR_WIDTH-1:0] long_ticks_q;
	logic [kpd_pkg::THR_WIDTH-1:0] min_ticks_q;
	logic                          rel_level_q;

	kpd_pkg::cnt_t    hold_q    [K];
	kpd_pkg::pstate_t state_q   [K];
	logic             lock_q    [K];
	kpd_pkg::cnt_t    hold_nxt  [K];
	kpd_pkg::pstate_t state_nxt [K];
	logic             lock_nxt  [K];

	kpd_pkg::res_t res_nxt;
	kpd_pkg::res_t res_q;
	kpd_pkg::res_t skid_q;
	logic          out_valid_q;
	logic          skid_valid_q;
	logic          accept;
	logic          out_free;

	logic [K-1:0]                       lv;
	logic [2*K+kpd_pkg::STATES_BITS-1:0] pk;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid & ~skid_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= kpd_pkg::LONG_TICKS_RST;
			min_ticks_q  <= kpd_pkg::MIN_TICKS_RST;
			rel_level_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				kpd_pkg::REG_LONG_TICKS: long_ticks_q <= cfg_data;
				kpd_pkg::REG_MIN_TICKS:  min_ticks_q  <= cfg_data;
				kpd_pkg::REG_REL_LEVEL:  rel_level_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		kpd_pkg::cnt_t inc;
		lv = K'(key_levels);
		pk = '0;
		res_nxt = '0;
		inc = '0;
		for (int k = 0; k < K; k++) begin
			hold_nxt[k]  = hold_q[k];
			state_nxt[k] = state_q[k];
			lock_nxt[k]  = lock_q[k];
			case (func)
				kpd_pkg::FN_SCAN: begin
					if (lv[k] != rel_level_q) begin
						inc = (hold_q[k] == kpd_pkg::CNT_MAX) ? hold_q[k]
							: hold_q[k] + kpd_pkg::cnt_t'(1);
						hold_nxt[k] = inc;
						if (lock_q[k]) begin
							state_nxt[k] = kpd_pkg::ST_RELEASED;
						end else if (32'(inc) >= 32'(long_ticks_q)) begin
							state_nxt[k] = kpd_pkg::ST_LONG;
							lock_nxt[k]  = 1'b1;
							res_nxt.beep = 1'b1;
						end
					end else begin
						if (!lock_q[k]) begin
							if (state_q[k] != kpd_pkg::ST_LONG &&
								32'(hold_q[k]) >= 32'(min_ticks_q)) begin
								state_nxt[k] = kpd_pkg::ST_SHORT;
								res_nxt.beep = 1'b1;
							end else begin
								state_nxt[k] = kpd_pkg::ST_RELEASED;
							end
						end
						hold_nxt[k] = '0;
						lock_nxt[k] = 1'b0;
					end
				end
				kpd_pkg::FN_CLR_ONE: begin
					if (32'(key_select) == k) state_nxt[k] = kpd_pkg::ST_RELEASED;
				end
				kpd_pkg::FN_CLR_ALL: state_nxt[k] = kpd_pkg::ST_RELEASED;
				default: ;
			endcase
			if (state_nxt[k] != kpd_pkg::ST_RELEASED) res_nxt.any_active = 1'b1;
			pk[2*k +: 2] = state_nxt[k];
		end
		res_nxt.key_states = pk[kpd_pkg::STATES_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < K; k++) begin
				hold_q[k]  <= '0;
				state_q[k] <= kpd_pkg::ST_RELEASED;
				lock_q[k]  <= 1'b0;
			end
		end else if (accept) begin
			for (int k = 0; k < K; k++) begin
				hold_q[k]  <= hold_nxt[k];
				state_q[k] <= state_nxt[k];
				lock_q[k]  <= lock_nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) res_q <= skid_q;
			else if (accept) res_q <= res_nxt;
		end else if (accept) begin
			skid_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_states = res_q.key_states;
	assign any_active = res_q.any_active;
	assign beep       = res_q.beep;

endmodule
`default_nettype wire

### rtl/core/kpd_checker.sv
`default_nettype none
`include "key_short_long_press_detector_unit_assert.svh"
module kpd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] key_states,
	input wire logic       any_active,
	input wire logic       beep
);

	`KPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`KPD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(key_states))
	`KPD_ASSERT_NEXT(a_take_gives_result, in_valid && !in_stall, out_valid)
	`KPD_ASSERT_SAME(a_beep_active, out_valid && beep, any_active)

endmodule

bind key_short_long_press_detector_unit kpd_checker u_kpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.key_states(key_states),
	.any_active(any_active),
	.beep(beep)
);
`default_nettype wire
